/* hw/rtl/slru_pkg.sv */
// ----------------------------------------------------------------------------
// slru_pkg
// Shared sizes, cell and segment command types for the segmented LRU policy.
// ----------------------------------------------------------------------------
package slru_pkg;

    localparam int MAX_SEGMENTS    = 4;
    localparam int SEGMENT_ENTRIES = 16;
    localparam int KEY_WIDTH       = 32;

    localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int POS_W = $clog2(SEGMENT_ENTRIES);
    localparam int CNT_W = $clog2(SEGMENT_ENTRIES + 1);
    localparam int NS_W  = $clog2(MAX_SEGMENTS + 1);

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_NUM_SEGMENTS     = 1'b0,
        REG_SEGMENT_CAPACITY = 1'b1
    } t_reg_idx;

    // What one cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } t_cell_op;

    // What a whole segment does this cycle
    typedef enum logic [1:0] {
        SEG_HOLD,
        SEG_REMOVE,
        SEG_PUSH
    } t_seg_op;

    typedef struct packed {
        t_seg_op              op;
        logic [POS_W-1:0]     pos;   // removal position
        logic [KEY_WIDTH-1:0] key;   // key pushed at the front
    } t_seg_cmd;

    typedef struct packed {
        logic                 hit;
        logic [POS_W-1:0]     hit_pos;
        logic [CNT_W-1:0]     count;
        logic [KEY_WIDTH-1:0] tail_key;
    } t_seg_stat;

endpackage

/* hw/rtl/slru_cell.sv */
// ----------------------------------------------------------------------------
// slru_cell
// One slot of a segment: holds a key, takes a neighbour's key on shifts.
// ----------------------------------------------------------------------------
module slru_cell (
    input  logic                          i_clk,
    input  slru_pkg::t_cell_op            i_op,
    input  logic [slru_pkg::KEY_WIDTH-1:0] i_left_key,
    input  logic [slru_pkg::KEY_WIDTH-1:0] i_right_key,
    input  logic [slru_pkg::KEY_WIDTH-1:0] i_match_key,
    output logic [slru_pkg::KEY_WIDTH-1:0] o_key,
    output logic                          o_match
);
    import slru_pkg::*;

    logic [KEY_WIDTH-1:0] r_key;

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_FROM_LEFT:  r_key <= i_left_key;
            CELL_FROM_RIGHT: r_key <= i_right_key;
            default:         r_key <= r_key;
        endcase
    end

    assign o_key   = r_key;
    assign o_match = (r_key == i_match_key);

endmodule

/* hw/rtl/slru_seg.sv */
// ----------------------------------------------------------------------------
// slru_seg
// One LRU segment: a row of cells, most recent at cell 0, plus its fill count.
// ----------------------------------------------------------------------------
module slru_seg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slru_pkg::t_seg_cmd            i_cmd,
    input  logic [slru_pkg::KEY_WIDTH-1:0] i_lookup_key,
    output slru_pkg::t_seg_stat           o_stat
);
    import slru_pkg::*;

    logic [KEY_WIDTH-1:0] w_key [SEGMENT_ENTRIES];
    logic [SEGMENT_ENTRIES-1:0] w_match;
    t_cell_op w_op [SEGMENT_ENTRIES];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] w_tail_idx;

    for (genvar p = 0; p < SEGMENT_ENTRIES; p++) begin : g_cell
        logic [KEY_WIDTH-1:0] w_left;
        logic [KEY_WIDTH-1:0] w_right;
        if (p == 0) begin : g_first
            assign w_left = i_cmd.key;
        end else begin : g_mid
            assign w_left = w_key[p-1];
        end
        if (p == SEGMENT_ENTRIES - 1) begin : g_last
            assign w_right = w_key[p];
        end else begin : g_inner
            assign w_right = w_key[p+1];
        end

        always_comb begin
            case (i_cmd.op)
                SEG_PUSH:   w_op[p] = CELL_FROM_LEFT;
                SEG_REMOVE: w_op[p] = (POS_W'(p) >= i_cmd.pos) ? CELL_FROM_RIGHT
                                                                : CELL_HOLD;
                default:    w_op[p] = CELL_HOLD;
            endcase
        end

        slru_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op[p]),
            .i_left_key  (w_left),
            .i_right_key (w_right),
            .i_match_key (i_lookup_key),
            .o_key       (w_key[p]),
            .o_match     (w_match[p])
        );
    end

    // first valid match, most recent wins
    always_comb begin
        o_stat.hit_pos = '0;
        for (int p = SEGMENT_ENTRIES - 1; p >= 0; p--) begin
            if (w_match[p] && (CNT_W'(p) < r_count)) begin
                o_stat.hit_pos = POS_W'(p);
            end
        end
    end

    always_comb begin
        logic [SEGMENT_ENTRIES-1:0] v;
        for (int p = 0; p < SEGMENT_ENTRIES; p++) begin
            v[p] = w_match[p] && (CNT_W'(p) < r_count);
        end
        o_stat.hit = |v;
    end

    assign w_tail_idx      = r_count - CNT_W'(1);
    assign o_stat.tail_key = w_key[w_tail_idx[POS_W-1:0]];
    assign o_stat.count    = r_count;

    always_comb begin
        n_count = r_count;
        case (i_cmd.op)
            SEG_REMOVE: if (r_count != '0) n_count = r_count - CNT_W'(1);
            SEG_PUSH:   if (r_count < CNT_W'(SEGMENT_ENTRIES)) n_count = r_count + CNT_W'(1);
            default:    n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

/* hw/rtl/segmented_lru_cache_policy.sv */
// ----------------------------------------------------------------------------
// segmented_lru_cache_policy
// Segmented LRU replacement policy built from rows of shifting key cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one object key per item.
//   Output channel: o_out_valid / i_out_stall carry one result per item
//   (hit flag, hit segment, evicted flag and key).
//   Each segment is a row of cells, most recent first; a hit or insert is
//   done as shifts along the rows, one phase per cycle but for a full result
//   register: accept -> lookup (all cells compare) -> remove -> push -> result.
//   An item goes through the lookup, remove, push and result phases in turn
//   before its result is loaded into the result register; the next item is
//   taken only once the block is back in its accept phase.
//   The result sits in an output register, so a new item is accepted while
//   the previous result is still stalled; the block waits in its result
//   phase only if that register is still full.
//   Reset (synchronous, active low) empties every segment and sets
//   num_segments to 2 and segment_capacity to 16. The user must make config
//   writes (i_cfg_we/i_cfg_index/i_cfg_data) only in idle; not enforced.
// ----------------------------------------------------------------------------
module segmented_lru_cache_policy (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [slru_pkg::KEY_WIDTH-1:0] i_object_key,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [1:0]                    o_hit_segment,
    output logic                          o_evicted_valid,
    output logic [31:0]                   o_evicted_key,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_index,
    input  logic [4:0]                    i_cfg_data
);
    import slru_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_LOOK, S_REM, S_PUSH, S_DONE} t_state;

    t_state r_state;
    logic [2:0] r_num_segments;
    logic [4:0] r_capacity;
    logic [KEY_WIDTH-1:0] r_key;
    logic r_hit, r_promote, r_demote, r_evict;
    logic [SEG_W-1:0] r_hs;
    logic [POS_W-1:0] r_pos;
    logic [KEY_WIDTH-1:0] r_down, r_ev_key;

    t_seg_cmd  w_cmd  [MAX_SEGMENTS];
    t_seg_stat w_stat [MAX_SEGMENTS];

    logic [NS_W-1:0] w_ns;     // effective segment count
    logic [CNT_W-1:0] w_cap;   // effective capacity
    logic [SEG_W-1:0] w_up;
    logic w_hit;
    logic [SEG_W-1:0] w_hs;
    logic [POS_W-1:0] w_pos;

    for (genvar s = 0; s < MAX_SEGMENTS; s++) begin : g_seg
        slru_seg u_seg (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd[s]),
            .i_lookup_key (r_key),
            .o_stat       (w_stat[s])
        );
    end

    // clamp configuration to the supported range
    always_comb begin
        if (r_num_segments == '0)
            w_ns = NS_W'(1);
        else if (r_num_segments > 3'(MAX_SEGMENTS))
            w_ns = NS_W'(MAX_SEGMENTS);
        else
            w_ns = NS_W'(r_num_segments);
        if (r_capacity == '0)
            w_cap = CNT_W'(1);
        else if (r_capacity > 5'(SEGMENT_ENTRIES))
            w_cap = CNT_W'(SEGMENT_ENTRIES);
        else
            w_cap = CNT_W'(r_capacity);
    end

    // lowest segment in use that holds the key
    always_comb begin
        w_hit = 1'b0;
        w_hs  = '0;
        w_pos = '0;
        for (int s = MAX_SEGMENTS - 1; s >= 0; s--) begin
            if (w_stat[s].hit && (NS_W'(s) < w_ns)) begin
                w_hit = 1'b1;
                w_hs  = SEG_W'(s);
                w_pos = w_stat[s].hit_pos;
            end
        end
    end

    assign w_up = r_hs + SEG_W'(1);

    // per-segment shift commands
    always_comb begin
        for (int s = 0; s < MAX_SEGMENTS; s++) begin
            logic [CNT_W-1:0] tail;
            tail = w_stat[s].count - CNT_W'(1);
            w_cmd[s].op  = SEG_HOLD;
            w_cmd[s].pos = tail[POS_W-1:0];
            w_cmd[s].key = r_key;
            if (r_state == S_REM) begin
                if (r_hit && SEG_W'(s) == r_hs) begin
                    w_cmd[s].op  = SEG_REMOVE;
                    w_cmd[s].pos = r_pos;
                end else if (r_demote && SEG_W'(s) == w_up) begin
                    w_cmd[s].op = SEG_REMOVE;
                end else if (r_evict && s == 0) begin
                    w_cmd[s].op = SEG_REMOVE;
                end
            end else if (r_state == S_PUSH) begin
                if (r_hit) begin
                    if (r_promote && SEG_W'(s) == w_up) begin
                        w_cmd[s].op = SEG_PUSH;
                    end else if (!r_promote && SEG_W'(s) == r_hs) begin
                        w_cmd[s].op = SEG_PUSH;
                    end else if (r_demote && SEG_W'(s) == r_hs) begin
                        w_cmd[s].op  = SEG_PUSH;
                        w_cmd[s].key = r_down;
                    end
                end else if (s == 0) begin
                    w_cmd[s].op = SEG_PUSH;
                end
            end
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_num_segments <= 3'd2;
            r_capacity     <= 5'd16;
            o_out_valid    <= 1'b0;
            r_hit          <= 1'b0;
            r_promote      <= 1'b0;
            r_demote       <= 1'b0;
            r_evict        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_NUM_SEGMENTS:     r_num_segments <= i_cfg_data[2:0];
                    REG_SEGMENT_CAPACITY: r_capacity     <= i_cfg_data;
                    default: ;
                endcase
            end
            // result taken and no new one loaded this cycle
            if (o_out_valid && !i_out_stall && r_state != S_DONE) o_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_key   <= i_object_key;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_hit     <= w_hit;
                    r_hs      <= w_hs;
                    r_pos     <= w_pos;
                    r_promote <= w_hit && ((NS_W'(w_hs) + NS_W'(1)) < w_ns);
                    r_demote  <= w_hit && ((NS_W'(w_hs) + NS_W'(1)) < w_ns)
                                 && (w_stat[SEG_W'(w_hs + SEG_W'(1))].count >= w_cap);
                    r_evict   <= !w_hit && (w_stat[0].count >= w_cap);
                    r_state   <= S_REM;
                end
                S_REM: begin
                    r_down   <= w_stat[w_up].tail_key;
                    r_ev_key <= w_stat[0].tail_key;
                    r_state  <= S_PUSH;
                end
                S_PUSH: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid     <= 1'b1;
                        o_hit           <= r_hit;
                        o_hit_segment   <= 2'(r_hs);
                        o_evicted_valid <= r_evict;
                        o_evicted_key   <= r_evict ? 32'(r_ev_key) : 32'd0;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared outside the result phase");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_evicted_valid))
        else $error("eviction reported on a hit");

    a_evict_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_evicted_valid) |-> (o_evicted_key == 32'd0))
        else $error("evicted key not zero without eviction");

    a_demote_needs_promote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REM) |-> (!r_demote || (r_promote && r_hit)))
        else $error("demotion without promotion");

endmodule
